// ----- hw/rtl/sequential_list_engine_core_defines.svh -----
// Assertion macros used by the list engine checker.
`ifndef SEQUENTIAL_LIST_ENGINE_CORE_DEFINES_SVH
`define SEQUENTIAL_LIST_ENGINE_CORE_DEFINES_SVH

// Check on every rising edge outside reset.
`define SLEC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every rising edge, reset included.
`define SLEC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/slec_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package slec_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_FIND   = 2'd2,
		OP_READ   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_BAD_POS   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Command broadcast to every cell for the length of one operation.
	typedef struct packed {
		op_t  op;
		logic ok;
	} cmd_t;

	// Control part of the wave that walks the chain.
	typedef struct packed {
		logic tok;
		logic found;
	} wave_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sequential_list_engine_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to DEPTH words with an entry count, held in a chain of
// DEPTH cells, one entry per cell. Each input beat is one operation: insert
// at a 1-based position (shifting later entries up), delete the first match
// (closing the gap), find the first match, or read at a 1-based position.
// One result beat follows each input beat. An operation runs as a wave that
// enters cell 0 and moves one cell per cycle to the far end. A new item is
// taken only once the previous one has left its last step. The result sits
// in an output register, so the next item is taken even while the previous
// result is still stalled; that item then holds in its last step until the
// output register is free, and stretches for as long as the stall lasts.
// No clearing pass is needed after reset: entries beyond the count are
// never looked at.

module sequential_list_engine_core #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  operation,
	input  wire  [31:0] item_value,
	input  wire  [6:0]  position,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [1:0]  status,
	output logic [5:0]  found_index,
	output logic [31:0] data_out,
	output logic [6:0]  entry_count,
	output logic        is_empty,
	output logic        is_full
);
	import slec_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = ((CW > 7) ? CW : 7) + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_FIN
	} state_t;

	state_t               state_q;
	logic [CW-1:0]        count_q;
	logic                 start_q;
	cmd_t                 cmd_q;
	logic [WORD_BITS-1:0] value_q;
	logic [IW-1:0]        at_q;
	status_t              pre_status_q;

	logic        out_valid_q;
	logic [1:0]  status_q;
	logic [5:0]  found_index_q;
	logic [31:0] data_out_q;
	logic [6:0]  entry_count_q;
	logic        is_empty_q;
	logic        is_full_q;

	// chain taps: index k is the wave leaving cell k-1 (k = 0 is the entry)
	wave_ctl_t            w_ctl  [0:DEPTH];
	logic [IW-1:0]        w_idx  [0:DEPTH];
	logic [WORD_BITS-1:0] w_data [0:DEPTH];
	logic [WORD_BITS-1:0] entry  [0:DEPTH-1];

	logic                     accept;
	logic [PW-1:0]            pos_w;
	logic [PW-1:0]            cnt_w;
	logic [PW-1:0]            at_w;
	logic                     list_full;
	logic                     ins_bad;
	logic                     rd_bad;
	logic [WORD_BITS+31:0]    value_ext;
	logic [WORD_BITS-1:0]     value_w;
	op_t                      op_in;
	cmd_t                     cmd_d;
	status_t                  pre_status_d;

	logic                  found_end;
	logic [CW-1:0]         count_d;
	status_t               status_d;
	logic [IW+5:0]         idx_ext;
	logic [5:0]            found_index_d;
	logic [WORD_BITS+31:0] val_ext;
	logic [WORD_BITS+31:0] rd_ext;
	logic [31:0]           data_d;
	logic [CW+6:0]         cnt_ext;
	logic                  out_free;

	assign accept = in_valid && !in_stall;
	assign op_in  = op_t'(operation);

	// operand checks against the count as it stands at acceptance
	assign pos_w     = PW'(position);
	assign cnt_w     = PW'(count_q);
	assign at_w      = pos_w - PW'(1);
	assign list_full = (count_q == CW'(DEPTH));
	assign ins_bad   = (pos_w == '0) || (pos_w > cnt_w + PW'(1));
	assign rd_bad    = (pos_w == '0) || (pos_w > cnt_w);
	assign value_ext = {{WORD_BITS{1'b0}}, item_value};
	assign value_w   = value_ext[WORD_BITS-1:0];

	always_comb begin
		pre_status_d = ST_OK;
		unique case (op_in)
			OP_INSERT: begin
				if (list_full) begin
					pre_status_d = ST_FULL;
				end else if (ins_bad) begin
					pre_status_d = ST_BAD_POS;
				end
			end
			OP_READ: begin
				if (rd_bad) begin
					pre_status_d = ST_BAD_POS;
				end
			end
			default: begin
			end
		endcase
		cmd_d.op = op_in;
		cmd_d.ok = (pre_status_d == ST_OK);
	end

	// the chain itself
	assign w_ctl[0]  = '{tok: start_q, found: 1'b0};
	assign w_idx[0]  = '0;
	assign w_data[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] nxt;
		if (i == DEPTH - 1) begin : g_last
			assign nxt = entry[i];
		end else begin : g_mid
			assign nxt = entry[i+1];
		end

		slec_cell #(
			.WORD_BITS (WORD_BITS),
			.IW        (IW),
			.CW        (CW),
			.I         (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd_q),
			.value     (value_q),
			.at        (at_q),
			.cnt       (count_q),
			.ctl_in    (w_ctl[i]),
			.idx_in    (w_idx[i]),
			.data_in   (w_data[i]),
			.next_data (nxt),
			.ctl_q     (w_ctl[i+1]),
			.idx_q     (w_idx[i+1]),
			.wdata_q   (w_data[i+1]),
			.data_q    (entry[i])
		);
	end

	// wrap up from what the wave carries out of the last cell (held there)
	assign found_end = w_ctl[DEPTH].found;
	assign idx_ext   = {6'b0, w_idx[DEPTH]};
	assign val_ext   = {32'b0, value_q};
	assign rd_ext    = {32'b0, w_data[DEPTH]};

	always_comb begin
		count_d       = count_q;
		status_d      = pre_status_q;
		found_index_d = '0;
		data_d        = '0;
		unique case (cmd_q.op)
			OP_INSERT: begin
				if (cmd_q.ok) begin
					count_d = count_q + CW'(1);
					data_d  = val_ext[31:0];
				end
			end
			OP_DELETE: begin
				if (found_end) begin
					count_d = count_q - CW'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			OP_FIND: begin
				if (found_end) begin
					found_index_d = idx_ext[5:0];
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			OP_READ: begin
				if (cmd_q.ok) begin
					data_d = rd_ext[31:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign cnt_ext  = {7'b0, count_d};
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			start_q       <= 1'b0;
			cmd_q         <= '0;
			value_q       <= '0;
			at_q          <= '0;
			pre_status_q  <= ST_OK;
			out_valid_q   <= 1'b0;
			status_q      <= '0;
			found_index_q <= '0;
			data_out_q    <= '0;
			entry_count_q <= '0;
			is_empty_q    <= 1'b1;
			is_full_q     <= 1'b0;
		end else begin
			// start_q registers the accept, so the wave launches in the cycle after the beat is taken
			start_q <= accept;
			// drop the result once downstream takes it; the last step loads the next one
			if (state_q != S_FIN && out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q        <= cmd_d;
						value_q      <= value_w;
						at_q         <= at_w[IW-1:0];
						pre_status_q <= pre_status_d;
						state_q      <= S_RUN;
					end
				end
				S_RUN: begin
					if (w_ctl[DEPTH].tok) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// hold here until the output register is free
					if (out_free) begin
						count_q       <= count_d;
						out_valid_q   <= 1'b1;
						status_q      <= status_d;
						found_index_q <= found_index_d;
						data_out_q    <= data_d;
						entry_count_q <= cnt_ext[6:0];
						is_empty_q    <= (count_d == '0);
						is_full_q     <= (count_d == CW'(DEPTH));
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_index_q;
	assign data_out    = data_out_q;
	assign entry_count = entry_count_q;
	assign is_empty    = is_empty_q;
	assign is_full     = is_full_q;

endmodule

`default_nettype wire

// ----- hw/rtl/slec_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module slec_cell #(
	parameter int WORD_BITS = 32,
	parameter int IW        = 6,
	parameter int CW        = 7,
	parameter int I         = 0
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  slec_pkg::cmd_t         cmd,
	input  wire  [WORD_BITS-1:0]   value,
	input  wire  [IW-1:0]          at,
	input  wire  [CW-1:0]          cnt,
	input  slec_pkg::wave_ctl_t    ctl_in,
	input  wire  [IW-1:0]          idx_in,
	input  wire  [WORD_BITS-1:0]   data_in,
	input  wire  [WORD_BITS-1:0]   next_data,
	output slec_pkg::wave_ctl_t    ctl_q,
	output logic [IW-1:0]          idx_q,
	output logic [WORD_BITS-1:0]   wdata_q,
	output logic [WORD_BITS-1:0]   data_q
);
	import slec_pkg::*;

	logic                 here;
	logic                 after;
	logic                 live;
	logic                 hit;
	logic                 found_d;
	logic [IW-1:0]        idx_d;
	logic [WORD_BITS-1:0] wdata_d;
	logic [WORD_BITS-1:0] data_d;

	assign here  = (at == IW'(I));
	assign after = (at < IW'(I));
	assign live  = (cnt > CW'(I));

	always_comb begin
		hit     = 1'b0;
		found_d = ctl_in.found;
		idx_d   = idx_in;
		wdata_d = data_in;
		data_d  = data_q;
		if (ctl_in.tok) begin
			unique case (cmd.op) inside
				OP_INSERT: begin
					// take the new word here, bubble the displaced one upward
					if (cmd.ok && here) begin
						data_d  = value;
						wdata_d = data_q;
					end else if (cmd.ok && after) begin
						data_d  = data_in;
						wdata_d = data_q;
					end
				end
				OP_DELETE, OP_FIND: begin
					hit     = !ctl_in.found && live && (data_q == value);
					found_d = ctl_in.found || hit;
					if (hit) begin
						idx_d = IW'(I);
					end
					// close the gap: upper neighbour is still untouched
					if (cmd.op == OP_DELETE && found_d) begin
						data_d = next_data;
					end
				end
				OP_READ: begin
					if (cmd.ok && here) begin
						wdata_d = data_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.tok <= ctl_in.tok;
			if (ctl_in.tok) begin
				ctl_q.found <= found_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
		if (ctl_in.tok) begin
			idx_q   <= idx_d;
			wdata_q <= wdata_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/slec_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "sequential_list_engine_core_defines.svh"

module slec_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [1:0]  status,
	input wire [5:0]  found_index,
	input wire [31:0] data_out,
	input wire [6:0]  entry_count,
	input wire        is_empty,
	input wire        is_full
);
	import slec_pkg::*;

	logic in_beat;
	logic fail;

	assign in_beat = in_valid && !in_stall;
	assign fail    = out_valid && (status != ST_OK);

	`SLEC_ASSERT_ALWAYS(a_no_result_in_reset, !arst_n |-> !out_valid, "result shown in reset")
	`SLEC_ASSERT(a_one_at_a_time, in_beat |=> in_stall, "second beat taken while busy")
	`SLEC_ASSERT(a_result_held, out_valid && out_stall |=> out_valid && $stable(status) && $stable(data_out), "stalled result changed")
	`SLEC_ASSERT(a_fail_zeroes, fail |-> found_index == 6'd0 && data_out == 32'd0, "failed operation carries data")
	`SLEC_ASSERT(a_count_flags, out_valid |-> (is_empty == (entry_count == 7'd0)) && !(is_empty && is_full), "count flags disagree")

endmodule

bind sequential_list_engine_core slec_checker u_slec_checker (.*);

`default_nettype wire
